// ===== rtl/core/selt_pkg.sv =====
// ----------------------------------------------------------------------------
// selt_pkg
// Shared types and constants for the shared/exclusive lease table.
// ----------------------------------------------------------------------------
package selt_pkg;

    localparam int unsigned TABLE_ENTRIES = 1024;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned NODE_SLOTS    = 32;
    localparam int unsigned PROBE_LIMIT   = 64;
    localparam int unsigned PROBE_W       = $clog2(PROBE_LIMIT + 1);

    localparam logic [1:0] OP_ACQUIRE  = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_RECLAIM  = 2'd2;
    localparam logic [1:0] OP_LIVENESS = 2'd3;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SH   = 2'd1;
    localparam logic [1:0] MODE_EX   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
    localparam logic [1:0] CFG_SELF_SLOT  = 2'd2;
    localparam logic [1:0] CFG_SELF_GEN   = 2'd3;

    // one table entry as stored in the entry memory
    typedef struct packed {
        logic        used;
        logic [63:0] resource;
        logic [1:0]  lmode;
        logic        owner_valid;
        logic [4:0]  owner_slot;
        logic [31:0] owner_gen;
        logic [31:0] holders;
    } entry_t;

    typedef struct packed {
        logic             wen;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== rtl/core/selt_entry_ram.sv =====
// ----------------------------------------------------------------------------
// selt_entry_ram
// Entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module selt_entry_ram (
    input  logic              aclk,
    input  selt_pkg::mem_req_t req,
    output selt_pkg::entry_t  rdata
);
    selt_pkg::entry_t mem [selt_pkg::TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.wen) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

// ===== rtl/core/shared_exclusive_lease_table_unit.sv =====
// ----------------------------------------------------------------------------
// shared_exclusive_lease_table_unit
// Lease table with bounded linear probing in an entry RAM (one write, one read port).
// Acquire/release: restoring division in S_PREP gives the start index, then each probe
//   reads (S_RD) and evaluates (S_EVAL) one entry, and S_DONE loads the result register;
//   reclaim does so for each entry under the effective size; liveness skips to S_DONE.
// One item at a time; the next transfer is taken the cycle after the result is
//   loaded, even while that result still waits on m_tready.
// Reset: synchronous active low; registers return to table_size 1024, node_count 32,
//   slot 0, generation 0; alive bits and generations clear; then a pass over all 1024
//   entries clears each one while s_tready stays low.
// ----------------------------------------------------------------------------
module shared_exclusive_lease_table_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: operation[1:0], resource[65:2], mode[66], node_slot[71:67],
    //        node_gen[103:72], node_alive[104], zero pad to 112
    input  logic [111:0] s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[1:0], entry_index[11:2], reclaimed_entries[22:12], pad to 24
    output logic [23:0]  m_tdata
);
    localparam int unsigned IW = selt_pkg::IDX_W;
    localparam int unsigned PW = selt_pkg::PROBE_W;

    typedef enum logic [2:0] {S_IDLE, S_PREP, S_RD, S_EVAL, S_RC_RD, S_RC_EVAL,
                              S_DONE, S_CLR} state_t;

    state_t state_reg;

    logic [10:0] table_size_reg;
    logic [5:0]  node_count_reg;
    logic [4:0]  self_slot_reg;
    logic [31:0] self_gen_reg;

    logic [31:0] alive_reg;
    logic [31:0] node_gen_reg [selt_pkg::NODE_SLOTS];

    // item latched at accept
    logic [1:0]  op_reg;
    logic [63:0] res_reg;
    logic        want_ex_reg;
    logic [4:0]  nslot_reg;
    logic [31:0] ngen_reg;

    logic [IW-1:0]              idx_reg;    // current probe/scan/clear entry
    logic [PW-1:0]              probe_reg;
    logic [IW:0]                size_reg;   // effective size
    logic [31:0]                mask_reg;   // node scan mask
    logic [10:0]                count_reg;

    logic [1:0]  st_reg;
    logic [IW-1:0] oidx_reg;

    // result register: holds one finished transfer so the core can go idle
    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        out_load;

    selt_pkg::mem_req_t req;
    selt_pkg::entry_t   rd;

    selt_entry_ram u_ram (.aclk(aclk), .req(req), .rdata(rd));

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // effective size and scan mask from registers
    logic [IW:0] eff_size;
    logic [31:0] eff_mask;
    always_comb begin
        if (table_size_reg == 11'd0)
            eff_size = (IW+1)'(1);
        else if ({21'd0, table_size_reg} > 32'(selt_pkg::TABLE_ENTRIES))
            eff_size = (IW+1)'(selt_pkg::TABLE_ENTRIES);
        else
            eff_size = (IW+1)'(table_size_reg);
        if (node_count_reg >= 6'd32) eff_mask = '1;
        else eff_mask = (32'd1 << node_count_reg[4:0]) - 32'd1;
    end

    // start index = resource mod size by restoring division,
    // one resource bit per cycle in S_PREP
    logic [6:0]  prep_cnt_reg;
    logic [IW:0] rem_reg;
    logic [IW+1:0] rem_sh;
    always_comb begin
        rem_sh = {rem_reg, res_reg[6'd63 - prep_cnt_reg[5:0]]};
    end

    // entry evaluation
    logic [31:0] self_bit;
    logic        used_now, mine, own_alive, live_all, live_oth, takeover;
    logic [4:0]  oslot;
    always_comb begin
        self_bit  = 32'd1 << self_slot_reg;
        used_now  = rd.used;
        mine      = used_now && (rd.resource == res_reg);
        oslot     = rd.owner_slot;
        own_alive = alive_reg[oslot] && (node_gen_reg[oslot] == rd.owner_gen);
        live_all  = (rd.holders & alive_reg & mask_reg) != 32'd0;
        live_oth  = (rd.holders & alive_reg & mask_reg & ~self_bit) != 32'd0;
        takeover  = !(rd.owner_valid && own_alive) && !live_all;
    end

    // next probe index with wrap; resource + probe wrapping past 2^64 restarts at 0
    logic [IW:0] idx_inc;
    logic [IW-1:0] idx_wrap;
    logic [PW-1:0] probe_next;
    logic          key_wrap;
    always_comb begin
        idx_inc    = {1'b0, idx_reg} + (IW+1)'(1);
        idx_wrap   = (idx_inc >= size_reg) ? '0 : idx_inc[IW-1:0];
        probe_next = probe_reg + PW'(1);
        key_wrap   = (&res_reg[63:6]) &&
                     (({1'b0, res_reg[5:0]} + 7'(probe_next)) == 7'd64);
    end

    // write data computed for the current entry
    selt_pkg::entry_t wr_acq, wr_rel, wr_rc;
    logic rc_touch;
    always_comb begin
        wr_acq      = rd;
        wr_acq.used = 1'b1;
        if (!mine) begin
            wr_acq.resource    = res_reg;
            wr_acq.owner_valid = 1'b0;
            wr_acq.owner_slot  = '0;
            wr_acq.owner_gen   = '0;
            wr_acq.holders     = '0;
        end
        if (want_ex_reg) begin
            wr_acq.owner_valid = 1'b1;
            wr_acq.owner_slot  = self_slot_reg;
            wr_acq.owner_gen   = self_gen_reg;
            wr_acq.lmode       = selt_pkg::MODE_EX;
        end else begin
            wr_acq.lmode       = selt_pkg::MODE_SH;
            wr_acq.owner_valid = 1'b0;
            wr_acq.holders     = wr_acq.holders | self_bit;
        end

        wr_rel = rd;
        if (want_ex_reg) begin
            wr_rel.lmode       = selt_pkg::MODE_NONE;
            wr_rel.owner_valid = 1'b0;
        end else begin
            wr_rel.holders = rd.holders & ~self_bit;
            if (!rd.owner_valid && ((wr_rel.holders & mask_reg) == 32'd0))
                wr_rel.lmode = selt_pkg::MODE_NONE;
        end

        wr_rc    = rd;
        rc_touch = 1'b0;
        if (rd.owner_valid && rd.owner_slot == nslot_reg && rd.owner_gen == ngen_reg) begin
            wr_rc.owner_valid = 1'b0;
            wr_rc.owner_gen   = '0;
            rc_touch          = 1'b1;
        end
        if (rd.holders[nslot_reg]) begin
            wr_rc.holders[nslot_reg] = 1'b0;
            rc_touch                 = 1'b1;
        end
        if (wr_rc.owner_valid) wr_rc.lmode = selt_pkg::MODE_EX;
        else if ((wr_rc.holders & mask_reg) != 32'd0) wr_rc.lmode = selt_pkg::MODE_SH;
        else wr_rc.lmode = selt_pkg::MODE_NONE;
    end

    // memory request
    always_comb begin
        req.raddr = idx_reg;
        req.waddr = idx_reg;
        req.wen   = 1'b0;
        req.wdata = wr_acq;
        if (state_reg == S_CLR) begin
            req.wen   = 1'b1;
            req.wdata = '0;
        end else if (state_reg == S_EVAL) begin
            if (op_reg == selt_pkg::OP_ACQUIRE) begin
                if (!used_now || mine || takeover) begin
                    if (!(used_now && ((rd.lmode == selt_pkg::MODE_EX && rd.owner_valid &&
                          rd.owner_slot != self_slot_reg && own_alive) ||
                         (want_ex_reg && rd.lmode == selt_pkg::MODE_SH && live_oth))))
                        req.wen = 1'b1;
                end
            end else if (mine) begin
                req.wen   = 1'b1;
                req.wdata = wr_rel;
            end
        end else if (state_reg == S_RC_EVAL) begin
            req.wen   = used_now && rc_touch;
            req.wdata = wr_rc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            table_size_reg <= 11'd1024;
            node_count_reg <= 6'd32;
            self_slot_reg  <= '0;
            self_gen_reg   <= '0;
            alive_reg      <= '0;
            for (int i = 0; i < selt_pkg::NODE_SLOTS; i++) node_gen_reg[i] <= '0;
        end else begin
            out_valid_reg <= out_load || (out_valid_reg && !m_tready);
            if (out_load) out_data_reg <= {1'b0, count_reg, oidx_reg, st_reg};
            if (cfg_valid) begin
                unique case (cfg_index)
                    selt_pkg::CFG_TABLE_SIZE: table_size_reg <= cfg_data[10:0];
                    selt_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data[5:0];
                    selt_pkg::CFG_SELF_SLOT:  self_slot_reg  <= cfg_data[4:0];
                    selt_pkg::CFG_SELF_GEN:   self_gen_reg   <= cfg_data;
                endcase
            end
            unique case (state_reg)
                S_CLR: begin
                    idx_reg <= idx_reg + IW'(1);
                    if (idx_reg == IW'(selt_pkg::TABLE_ENTRIES - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= s_tdata[1:0];
                        res_reg     <= s_tdata[65:2];
                        want_ex_reg <= s_tdata[66];
                        nslot_reg   <= s_tdata[71:67];
                        ngen_reg    <= s_tdata[103:72];
                        size_reg    <= eff_size;
                        mask_reg    <= eff_mask;
                        count_reg   <= '0;
                        st_reg      <= selt_pkg::ST_OK;
                        oidx_reg    <= '0;
                        probe_reg   <= '0;
                        idx_reg     <= '0;
                        rem_reg     <= '0;
                        prep_cnt_reg <= '0;
                        unique case (s_tdata[1:0])
                            selt_pkg::OP_LIVENESS: begin
                                alive_reg[s_tdata[71:67]]    <= s_tdata[104];
                                node_gen_reg[s_tdata[71:67]] <= s_tdata[103:72];
                                state_reg <= S_DONE;
                            end
                            selt_pkg::OP_RECLAIM: state_reg <= S_RC_RD;
                            default: begin
                                if (s_tdata[1:0] == selt_pkg::OP_ACQUIRE)
                                    st_reg <= selt_pkg::ST_FULL;
                                state_reg <= S_PREP;
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    // one remainder bit per cycle: 64 bits, then hand over
                    if (rem_sh >= {1'b0, size_reg})
                        rem_reg <= (IW+1)'(rem_sh - {1'b0, size_reg});
                    else
                        rem_reg <= rem_sh[IW:0];
                    prep_cnt_reg <= prep_cnt_reg + 7'd1;
                    if (prep_cnt_reg == 7'd64) begin
                        idx_reg   <= rem_reg[IW-1:0];
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_EVAL;
                S_EVAL: begin
                    if (used_now && !mine &&
                        !(op_reg == selt_pkg::OP_ACQUIRE && takeover)) begin
                        probe_reg <= probe_next;
                        idx_reg   <= key_wrap ? '0 : idx_wrap;
                        if (32'(probe_reg) == selt_pkg::PROBE_LIMIT - 1) begin
                            oidx_reg  <= '0;
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_RD;
                        end
                    end else begin
                        oidx_reg  <= idx_reg;
                        state_reg <= S_DONE;
                        if (op_reg == selt_pkg::OP_RELEASE) st_reg <= selt_pkg::ST_OK;
                        else if (req.wen) st_reg <= selt_pkg::ST_OK;
                        else st_reg <= selt_pkg::ST_BUSY;
                    end
                end
                S_RC_RD: state_reg <= S_RC_EVAL;
                S_RC_EVAL: begin
                    if (req.wen) count_reg <= count_reg + 11'd1;
                    if (idx_inc >= size_reg) state_reg <= S_DONE;
                    else begin
                        idx_reg   <= idx_inc[IW-1:0];
                        state_reg <= S_RC_RD;
                    end
                end
                S_DONE: if (out_load) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shared/exclusive lease table. A directed table
// of lease operations runs first, then random traffic over several register
// settings; every result transfer is compared with a local lease predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TABLE_N   = selt_pkg::TABLE_ENTRIES;
    localparam int LIMIT_CYC = 20000000;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;

    shared_exclusive_lease_table_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] res;
        logic        excl;
        logic [4:0]  nslot;
        logic [31:0] ngen;
        logic        nalive;
    } lease_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  index;
        logic [10:0] count;
    } lease_ans_t;

    // ---------------- predictor state ----------------
    logic [10:0] cur_size;
    logic [5:0]  cur_nodes;
    logic [4:0]  cur_self;
    logic [31:0] cur_gen;
    logic        t_used   [TABLE_N];
    logic [63:0] t_res    [TABLE_N];
    logic [1:0]  t_mode   [TABLE_N];
    logic        t_ovld   [TABLE_N];
    logic [4:0]  t_oslot  [TABLE_N];
    logic [31:0] t_ogen   [TABLE_N];
    logic [31:0] t_hold   [TABLE_N];
    logic [31:0] alive_bits;
    logic [31:0] node_gens [32];

    lease_ans_t answers_due[$];
    int  fail_cnt;
    int  result_cnt;
    int  cycle_cnt;
    int  sent_cnt;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_recv;

    function automatic int unsigned eff_size();
        if (cur_size == 0) return 1;
        if (cur_size > TABLE_N) return TABLE_N;
        return cur_size;
    endfunction

    function automatic logic [31:0] holder_scan();
        if (cur_nodes >= 32) return 32'hFFFF_FFFF;
        return (32'd1 << cur_nodes) - 1;
    endfunction

    function automatic bit owner_live(logic [4:0] s, logic [31:0] g);
        return alive_bits[s] && node_gens[s] == g;
    endfunction

    function automatic bit holders_live(int i, logic [31:0] excl);
        return (t_hold[i] & alive_bits & holder_scan() & ~excl) != 0;
    endfunction

    // Computes the answer of one lease request and updates the shadow table.
    function automatic lease_ans_t predict_lease(lease_req_t r);
        lease_ans_t a;
        int unsigned sz;
        logic [31:0] me;
        logic [31:0] bitn;
        int i;
        int p;
        bit used;
        bit mine;
        bit acq;
        bit touched;
        bit take;
        a = '0;
        sz = eff_size();
        me = 32'd1 << cur_self;
        if (r.op == selt_pkg::OP_ACQUIRE || r.op == selt_pkg::OP_RELEASE) begin
            acq = (r.op == selt_pkg::OP_ACQUIRE);
            if (acq) a.status = selt_pkg::ST_FULL;
            for (p = 0; p < selt_pkg::PROBE_LIMIT; p++) begin
                i = int'((r.res + 64'(p)) % 64'(sz));
                used = t_used[i];
                mine = used && t_res[i] == r.res;
                take = acq && !(t_ovld[i] && owner_live(t_oslot[i], t_ogen[i]))
                       && !holders_live(i, 0);
                if (used && !mine && !take) continue;
                a.index = i[9:0];
                if (!acq) begin
                    a.status = selt_pkg::ST_OK;
                    if (mine) begin
                        if (r.excl) begin
                            t_mode[i] = selt_pkg::MODE_NONE;
                            t_ovld[i] = 1'b0;
                        end else begin
                            t_hold[i] &= ~me;
                            if (!t_ovld[i] && (t_hold[i] & holder_scan()) == 0)
                                t_mode[i] = selt_pkg::MODE_NONE;
                        end
                    end
                    break;
                end
                if (used) begin
                    if (t_mode[i] == selt_pkg::MODE_EX && t_ovld[i] && t_oslot[i] != cur_self
                        && owner_live(t_oslot[i], t_ogen[i])) begin
                        a.status = selt_pkg::ST_BUSY;
                        break;
                    end
                    if (r.excl && t_mode[i] == selt_pkg::MODE_SH && holders_live(i, me)) begin
                        a.status = selt_pkg::ST_BUSY;
                        break;
                    end
                end
                if (!mine) begin
                    t_used[i] = 1'b1;
                    t_res[i] = r.res;
                    t_mode[i] = selt_pkg::MODE_NONE;
                    t_ovld[i] = 1'b0;
                    t_oslot[i] = '0;
                    t_ogen[i] = '0;
                    t_hold[i] = '0;
                end
                if (r.excl) begin
                    t_ovld[i] = 1'b1;
                    t_oslot[i] = cur_self;
                    t_ogen[i] = cur_gen;
                    t_mode[i] = selt_pkg::MODE_EX;
                end else begin
                    t_mode[i] = selt_pkg::MODE_SH;
                    t_ovld[i] = 1'b0;
                    t_hold[i] |= me;
                end
                a.status = selt_pkg::ST_OK;
                break;
            end
            if (p >= selt_pkg::PROBE_LIMIT) a.index = '0;
        end else if (r.op == selt_pkg::OP_RECLAIM) begin
            bitn = 32'd1 << r.nslot;
            for (i = 0; i < int'(sz); i++) begin
                touched = 0;
                if (!t_used[i]) continue;
                if (t_ovld[i] && t_oslot[i] == r.nslot && t_ogen[i] == r.ngen) begin
                    t_ovld[i] = 1'b0;
                    t_ogen[i] = '0;
                    touched = 1;
                end
                if (t_hold[i] & bitn) begin
                    t_hold[i] &= ~bitn;
                    touched = 1;
                end
                if (!touched) continue;
                if (t_ovld[i]) t_mode[i] = selt_pkg::MODE_EX;
                else t_mode[i] = (t_hold[i] & holder_scan()) ? selt_pkg::MODE_SH
                                                              : selt_pkg::MODE_NONE;
                a.count++;
            end
        end else begin
            alive_bits[r.nslot] = r.nalive;
            node_gens[r.nslot] = r.ngen;
        end
        return a;
    endfunction

    // ---------------- clock, reset, limit ----------------
    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt > LIMIT_CYC) begin
                $display("timeout at %0t", $time);
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ---------------- result side ----------------
    // Receiver stalls at random; hold_recv forces a long hold-off.
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_recv) m_tready <= 0;
            else m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Each result transfer is matched against the oldest expected answer.
    always @(posedge aclk) begin
        lease_ans_t got;
        lease_ans_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[11:2], m_tdata[22:12]};
            result_cnt++;
            if (answers_due.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected result %h", $time, m_tdata);
            end else begin
                want = answers_due.pop_front();
                if (got.status != want.status) begin
                    fail_cnt++;
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                end
                if (got.index != want.index) begin
                    fail_cnt++;
                    $display("%0t: entry exp %0d got %0d", $time, want.index, got.index);
                end
                if (got.count != want.count) begin
                    fail_cnt++;
                    $display("%0t: reclaimed exp %0d got %0d", $time, want.count, got.count);
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    // tvalid stays up after a transfer unless the next item starts with idle cycles
    task automatic send_lease(lease_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {7'd0, r.nalive, r.ngen, r.nslot, r.excl, r.res, r.op};
        do @(posedge aclk); while (!s_tready);
        answers_due.push_back(predict_lease(r));
        sent_cnt++;
    endtask

    // Waits for the last answer, then lets a full reclaim walk drain.
    task automatic drain();
        s_tvalid <= 0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (2 * TABLE_N + 20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
        case (idx)
            selt_pkg::CFG_TABLE_SIZE: cur_size  = val[10:0];
            selt_pkg::CFG_NODE_COUNT: cur_nodes = val[5:0];
            selt_pkg::CFG_SELF_SLOT:  cur_self  = val[4:0];
            default:                  cur_gen   = val;
        endcase
    endtask

    // Random items: mostly lease traffic over a small key set with live nodes.
    function automatic lease_req_t rand_lease(int keys);
        lease_req_t r;
        int k;
        k = $urandom_range(99);
        r.op     = (k < 45) ? selt_pkg::OP_ACQUIRE : (k < 75) ? selt_pkg::OP_RELEASE :
                   (k < 82) ? selt_pkg::OP_RECLAIM : selt_pkg::OP_LIVENESS;
        r.res    = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(keys - 1));
        r.excl   = 1'($urandom_range(1));
        r.nslot  = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
        r.ngen   = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1));
        r.nalive = ($urandom_range(3) != 0);
        return r;
    endfunction

    // Directed rows: op, resource, excl, slot, gen, alive, check flag, answer.
    typedef struct {
        lease_req_t r;
        bit         fixed;
        lease_ans_t a;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{'{selt_pkg::OP_RELEASE, 64'd5, 1'b0, 5'd0, 32'd0, 1'b0}, 1,
          '{selt_pkg::ST_OK, 10'd5, 11'd0}},
        '{'{selt_pkg::OP_ACQUIRE, 64'd5, 1'b1, 5'd0, 32'd0, 1'b0}, 1,
          '{selt_pkg::ST_OK, 10'd5, 11'd0}},
        '{'{selt_pkg::OP_LIVENESS, 64'd0, 1'b0, 5'd0, 32'd0, 1'b1}, 1,
          '{selt_pkg::ST_OK, 10'd0, 11'd0}},
        '{'{selt_pkg::OP_LIVENESS, 64'd0, 1'b0, 5'd31, 32'hFFFF_FFFF, 1'b1}, 0, '0},
        '{'{selt_pkg::OP_ACQUIRE, 64'd1029, 1'b0, 5'd0, 32'd0, 1'b0}, 0, '0},
        '{'{selt_pkg::OP_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 5'd0, 32'd0, 1'b0}, 0, '0},
        '{'{selt_pkg::OP_ACQUIRE, 64'd5, 1'b0, 5'd0, 32'd0, 1'b0}, 0, '0},
        '{'{selt_pkg::OP_RELEASE, 64'd5, 1'b1, 5'd0, 32'd0, 1'b0}, 0, '0},
        '{'{selt_pkg::OP_RELEASE, 64'd5, 1'b0, 5'd0, 32'd0, 1'b0}, 0, '0},
        '{'{selt_pkg::OP_RECLAIM, 64'd0, 1'b0, 5'd0, 32'd0, 1'b0}, 0, '0},
        '{'{selt_pkg::OP_RECLAIM, 64'd0, 1'b1, 5'd31, 32'hFFFF_FFFF, 1'b1}, 0, '0},
        '{'{selt_pkg::OP_LIVENESS, 64'd0, 1'b1, 5'd0, 32'd0, 1'b0}, 0, '0},
        '{'{selt_pkg::OP_ACQUIRE, 64'd1029, 1'b1, 5'd0, 32'd0, 1'b0}, 0, '0},
        '{'{selt_pkg::OP_RELEASE, 64'h8000_0000_0000_0000, 1'b1, 5'd0, 32'd0, 1'b0}, 0, '0}
    };

    // ---------------- main sequence ----------------
    initial begin
        lease_req_t r;
        lease_ans_t want;
        int phase;
        int n;
        fail_cnt = 0; result_cnt = 0; sent_cnt = 0;
        hold_recv = 0;
        send_idle_pct = 24; recv_idle_pct = 49;
        aresetn = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 0; s_tdata = '0;
        cur_size = 1024; cur_nodes = 32; cur_self = 0; cur_gen = 0;
        alive_bits = '0;
        for (int i = 0; i < TABLE_N; i++) begin
            t_used[i] = 0; t_res[i] = '0; t_mode[i] = selt_pkg::MODE_NONE; t_ovld[i] = 0;
            t_oslot[i] = '0; t_ogen[i] = '0; t_hold[i] = '0;
        end
        for (int i = 0; i < 32; i++) node_gens[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed table at reset settings; fixed rows also check the predictor
        foreach (dir_rows[k]) begin
            if (dir_rows[k].fixed) begin
                r = dir_rows[k].r;
                send_lease(r);
                want = answers_due[$];
                if (want != dir_rows[k].a) begin
                    fail_cnt++;
                    $display("%0t: row %0d exp %h got %h", $time, k, dir_rows[k].a, want);
                end
            end else begin
                send_lease(dir_rows[k].r);
            end
        end
        drain();

        // settings sweep: tiny table to exhaust probes, odd node counts, extremes
        for (phase = 0; phase < 6; phase++) begin
            if (phase == 2) begin send_idle_pct = 49; recv_idle_pct = 24; end
            if (phase == 4) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            case (phase)
                0: begin
                    write_reg(selt_pkg::CFG_TABLE_SIZE, 32'd8);
                    write_reg(selt_pkg::CFG_NODE_COUNT, 32'd4);
                end
                1: begin
                    write_reg(selt_pkg::CFG_TABLE_SIZE, 32'd0);
                    write_reg(selt_pkg::CFG_NODE_COUNT, 32'd1);
                end
                2: begin
                    write_reg(selt_pkg::CFG_TABLE_SIZE, 32'd2047);
                    write_reg(selt_pkg::CFG_NODE_COUNT, 32'd63);
                end
                3: begin
                    write_reg(selt_pkg::CFG_TABLE_SIZE, 32'd37);
                    write_reg(selt_pkg::CFG_NODE_COUNT, 32'd0);
                end
                4: begin
                    write_reg(selt_pkg::CFG_TABLE_SIZE, 32'd1);
                    write_reg(selt_pkg::CFG_NODE_COUNT, 32'd32);
                end
                default: begin
                    write_reg(selt_pkg::CFG_TABLE_SIZE, 32'd64);
                    write_reg(selt_pkg::CFG_NODE_COUNT, 32'd3);
                end
            endcase
            write_reg(selt_pkg::CFG_SELF_SLOT,
                      (phase == 2) ? 32'd31 : 32'($urandom_range(3)));
            write_reg(selt_pkg::CFG_SELF_GEN,
                      (phase == 2) ? 32'hFFFF_FFFF : 32'($urandom_range(1)));
            if (phase == 3) begin
                // probe walk whose resource + probe wraps past the top of the key space
                send_lease('{selt_pkg::OP_LIVENESS, 64'd0, 1'b0, cur_self, cur_gen, 1'b1});
                send_lease('{selt_pkg::OP_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFDA, 1'b1,
                             5'd0, 32'd0, 1'b0});
                send_lease('{selt_pkg::OP_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                             5'd0, 32'd0, 1'b0});
            end
            if (phase == 4) begin
                // long receiver hold-off while the sender keeps offering items
                fork
                    begin
                        hold_recv = 1;
                        repeat (300) @(posedge aclk);
                        hold_recv = 0;
                    end
                join_none
            end
            for (n = 0; n < 255; n++) send_lease(rand_lease(phase == 1 ? 3 : 80));
            drain();
        end

        $display("ran %0d lease requests over 6 register settings, %0d results checked",
                 sent_cnt, result_cnt);
        if (fail_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule
